// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- rtl/core/dmck_pkg.sv -----
// types and constants for the dual monod kinetics core
`default_nettype none

package dmck_pkg;

    localparam int ValW  = 32;
    localparam int FracW = 17;
    localparam int QuoW  = 47;
    localparam int OutW  = 48;
    localparam int NetW  = 36;
    localparam int ProdW = 64;

    // 1.15 in q16.16
    localparam logic [16:0] Q16_1P15 = 17'd75366;
    localparam logic [QuoW-1:0] CAP47 = {QuoW{1'b1}};

    typedef enum logic [2:0] {
        REG_MAX_GROWTH   = 3'd0,
        REG_YIELD        = 3'd1,
        REG_MAINTENANCE  = 3'd2,
        REG_DECAY        = 3'd3,
        REG_OXY_AFFINITY = 3'd4,
        REG_NIT_AFFINITY = 3'd5,
        REG_REACT_EN     = 3'd6,
        REG_GROWTH_EN    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] oxygen_conc;
        logic [31:0] nitrite_conc;
        logic [31:0] biomass_density;
        logic        ghost_cell;
        logic        last_cell;
    } cell_t;

    typedef struct packed {
        logic signed [47:0] nitrite_delta;
        logic signed [47:0] oxygen_delta;
        logic signed [47:0] nitrate_delta;
        logic               reaction_valid;
        logic signed [47:0] net_growth;
        logic               growth_valid;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic rv;
        logic gv;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic            zero;
        logic [ValW-1:0] dens;
        ctl_t            ctl;
    } fside_t;

    typedef struct packed {
        logic [ProdW-1:0]      p;
        logic [QuoW-1:0]       mm;
        logic signed [NetW-1:0] net;
        ctl_t                  ctl;
    } gout_t;

    typedef struct packed {
        logic                  force_zero;
        logic                  force_cap;
        logic [QuoW-1:0]       s;
        logic [QuoW-1:0]       mm;
        logic signed [NetW-1:0] net;
        ctl_t                  ctl;
    } qside_t;

endpackage

`default_nettype wire

// ----- rtl/core/dmck_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module dmck_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic [DEN_W-1:0]  rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  lq_reg   [0:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [SIDE_W-1:0] side_reg [0:QUO_W];
    logic [QUO_W:0]    vld_reg;

    // entry stage: high numerator bits form the first partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num >> QUO_W);
            lq_reg[0]   <= num[QUO_W-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], lq_reg[k][QUO_W-1]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                lq_reg[k+1]   <= {lq_reg[k][QUO_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = lq_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

`default_nettype wire

// ----- rtl/core/dmck_growth.sv -----
// growth and maintenance products, three multiply stages
`default_nettype none

module dmck_growth
    import dmck_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [FracW-1:0]  fo,
    input  wire logic [FracW-1:0]  fn,
    input  wire logic [ValW-1:0]   dens,
    input  wire ctl_t              ctl,
    input  wire logic [ValW-1:0]   mu,
    input  wire logic [ValW-1:0]   maint,
    input  wire logic [ValW-1:0]   dec,
    output logic                   out_valid,
    output gout_t                  out
);

    logic [2:0]       vld_reg;
    // stage 1
    logic [32:0]      t1_reg;
    logic [32:0]      m1_reg;
    logic [FracW-1:0] fo1_reg;
    logic [ValW-1:0]  dens1_reg;
    ctl_t             ctl1_reg;
    // stage 2
    logic [33:0]      g2_reg;
    logic [32:0]      m2_reg;
    logic [ValW-1:0]  dens2_reg;
    ctl_t             ctl2_reg;
    // stage 3
    gout_t            out_reg;

    logic [48:0] p_mu;
    logic [48:0] p_maint;
    logic [49:0] p_g;
    logic [65:0] p_gd;
    logic [64:0] p_md;
    logic [63:0] md_sat;
    logic [47:0] md_sh;
    gout_t       out_next;

    always_comb
    begin
        p_mu    = 49'(mu) * 49'(fn);
        p_maint = 49'(maint) * 49'(fo);
        p_g     = 50'(t1_reg) * 50'(fo1_reg);
    end

    always_comb
    begin
        p_gd   = 66'(g2_reg) * 66'(dens2_reg);
        p_md   = 65'(m2_reg) * 65'(dens2_reg);
        md_sat = p_md[64] ? {64{1'b1}} : p_md[63:0];
        md_sh  = md_sat[63:16];
        out_next.p   = (|p_gd[65:64]) ? {ProdW{1'b1}} : p_gd[63:0];
        out_next.mm  = md_sh[47] ? CAP47 : md_sh[46:0];
        out_next.net = NetW'(g2_reg) - NetW'(m2_reg) - NetW'(dec);
        out_next.ctl = ctl2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= p_mu[48:16];
            m1_reg    <= p_maint[48:16];
            fo1_reg   <= fo;
            dens1_reg <= dens;
            ctl1_reg  <= ctl;
            g2_reg    <= p_g[49:16];
            m2_reg    <= m1_reg;
            dens2_reg <= dens1_reg;
            ctl2_reg  <= ctl1_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out       = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dual_monod_cell_kinetics_core.sv -----
// order of stages is fraction dividers, growth, yield divider, scale, result register
// throughput: one cell per cycle unless stalled, set by pipelined dividers and multipliers
// the two monod fraction dividers take 18 stages, the yield divider 48 stages
// a result stall freezes the whole pipeline in place; nothing is dropped or repeated
// reset clears all valid bits and loads the register defaults (yield 1.0, rest zero)
`default_nettype none

module dual_monod_cell_kinetics_core
    import dmck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // cell stream
    input  wire logic        cell_valid,
    output logic             cell_stall,
    input  wire cell_t       cell_data,
    // result stream
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "assert_macros.svh"

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [ValW-1:0] mu_reg;
    logic [ValW-1:0] yield_reg;
    logic [ValW-1:0] maint_reg;
    logic [ValW-1:0] decay_reg;
    logic [ValW-1:0] ko_reg;
    logic [ValW-1:0] kn_reg;
    logic            react_en_reg;
    logic            growth_en_reg;

    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg        <= '0;
            yield_reg     <= 32'd65536;
            maint_reg     <= '0;
            decay_reg     <= '0;
            ko_reg        <= '0;
            kn_reg        <= '0;
            react_en_reg  <= 1'b0;
            growth_en_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_GROWTH:   mu_reg        <= pwdata;
                REG_YIELD:        yield_reg     <= pwdata;
                REG_MAINTENANCE:  maint_reg     <= pwdata;
                REG_DECAY:        decay_reg     <= pwdata;
                REG_OXY_AFFINITY: ko_reg        <= pwdata;
                REG_NIT_AFFINITY: kn_reg        <= pwdata;
                REG_REACT_EN:     react_en_reg  <= pwdata[0];
                REG_GROWTH_EN:    growth_en_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_GROWTH:   prdata = mu_reg;
            REG_YIELD:        prdata = yield_reg;
            REG_MAINTENANCE:  prdata = maint_reg;
            REG_DECAY:        prdata = decay_reg;
            REG_OXY_AFFINITY: prdata = ko_reg;
            REG_NIT_AFFINITY: prdata = kn_reg;
            REG_REACT_EN:     prdata = {31'd0, react_en_reg};
            REG_GROWTH_EN:    prdata = {31'd0, growth_en_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline advance: everything moves unless the output is blocked
    // ---------------------------------------------------------------
    logic en;
    assign en         = !(result_valid && result_stall);
    assign cell_stall = !en;

    // ---------------------------------------------------------------
    // monod fractions fo = o/(ko+o), fn = n/(kn+n), q1.16
    // ---------------------------------------------------------------
    logic [ValW:0] den_o;
    logic [ValW:0] den_n;
    fside_t        fo_side_in;
    fside_t        fo_side_out;
    logic          fn_zero_out;
    logic          fo_valid;
    logic          fn_valid;
    logic [FracW-1:0] fo_quo;
    logic [FracW-1:0] fn_quo;
    logic [FracW-1:0] fo_val;
    logic [FracW-1:0] fn_val;

    always_comb
    begin
        den_o = {1'b0, cell_data.oxygen_conc} + {1'b0, ko_reg};
        den_n = {1'b0, cell_data.nitrite_conc} + {1'b0, kn_reg};
        fo_side_in.zero     = (den_o == '0);
        fo_side_in.dens     = cell_data.biomass_density;
        // ghost cells never react
        fo_side_in.ctl.rv   = react_en_reg && !cell_data.ghost_cell;
        fo_side_in.ctl.gv   = growth_en_reg;
        fo_side_in.ctl.last = cell_data.last_cell;
    end

    dmck_div #(
        .NUM_W  (ValW + 16),
        .DEN_W  (ValW + 1),
        .QUO_W  (FracW),
        .SIDE_W ($bits(fside_t))
    ) u_div_oxy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cell_valid),
        .num      ({cell_data.oxygen_conc, 16'd0}),
        .den      (den_o),
        .in_side  (fo_side_in),
        .out_valid(fo_valid),
        .quo      (fo_quo),
        .out_side (fo_side_out)
    );

    dmck_div #(
        .NUM_W  (ValW + 16),
        .DEN_W  (ValW + 1),
        .QUO_W  (FracW),
        .SIDE_W (1)
    ) u_div_nit (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cell_valid),
        .num      ({cell_data.nitrite_conc, 16'd0}),
        .den      (den_n),
        .in_side  (den_n == '0),
        .out_valid(fn_valid),
        .quo      (fn_quo),
        .out_side (fn_zero_out)
    );

    // a zero denominator yields a zero fraction
    assign fo_val = fo_side_out.zero ? '0 : fo_quo;
    assign fn_val = fn_zero_out ? '0 : fn_quo;

    // ---------------------------------------------------------------
    // growth, maintenance and their products with density
    // ---------------------------------------------------------------
    logic  g_valid;
    gout_t g_out;

    dmck_growth u_growth (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fo_valid && fn_valid),
        .fo       (fo_val),
        .fn       (fn_val),
        .dens     (fo_side_out.dens),
        .ctl      (fo_side_out.ctl),
        .mu       (mu_reg),
        .maint    (maint_reg),
        .dec      (decay_reg),
        .out_valid(g_valid),
        .out      (g_out)
    );

    // ---------------------------------------------------------------
    // yield division q = p / y, capped at 2^47-1
    // ---------------------------------------------------------------
    qside_t      q_side_in;
    qside_t      q_side_out;
    logic        q_valid;
    logic [QuoW-1:0] q_quo;
    logic [47:0] s_full;

    always_comb
    begin
        s_full = g_out.p[63:16];
        q_side_in.force_zero = (yield_reg == '0);
        // quotient would need more than 47 bits
        q_side_in.force_cap  = ({15'd0, g_out.p[63:47]} >= yield_reg);
        q_side_in.s          = s_full[47] ? CAP47 : s_full[46:0];
        q_side_in.mm         = g_out.mm;
        q_side_in.net        = g_out.net;
        q_side_in.ctl        = g_out.ctl;
    end

    dmck_div #(
        .NUM_W  (ProdW),
        .DEN_W  (ValW),
        .QUO_W  (QuoW),
        .SIDE_W ($bits(qside_t))
    ) u_div_yield (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (g_valid),
        .num      (g_out.p),
        .den      (yield_reg),
        .in_side  (q_side_in),
        .out_valid(q_valid),
        .quo      (q_quo),
        .out_side (q_side_out)
    );

    // ---------------------------------------------------------------
    // scale stage: a = 1.15 * q
    // ---------------------------------------------------------------
    logic            e_valid_reg;
    logic [QuoW-1:0] e_q_reg;
    logic [47:0]     e_a_reg;
    qside_t          e_side_reg;
    logic [QuoW-1:0] q_final;
    logic [63:0]     a_prod;

    always_comb
    begin
        if (q_side_out.force_zero)
        begin
            q_final = '0;
        end
        else if (q_side_out.force_cap)
        begin
            q_final = CAP47;
        end
        else
        begin
            q_final = q_quo;
        end
        a_prod = 64'(Q16_1P15) * 64'(q_final);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_q_reg    <= q_final;
            e_a_reg    <= a_prod[63:16];
            e_side_reg <= q_side_out;
        end
    end

    // ---------------------------------------------------------------
    // output stage: deltas, saturation and the result register
    // ---------------------------------------------------------------
    logic signed [49:0] oxy_sum;
    logic signed [49:0] oxy_neg;
    logic signed [47:0] oxy_sat;
    logic signed [47:0] q_signed;
    result_t            result_next;
    result_t            result_reg;
    logic               result_valid_reg;

    always_comb
    begin
        oxy_sum  = $signed(50'(e_a_reg)) - $signed(50'(e_side_reg.s))
                   + $signed(50'(e_side_reg.mm));
        oxy_neg  = -oxy_sum;
        // clamp into the signed 48-bit range
        if (oxy_neg > $signed(50'(CAP47)))
        begin
            oxy_sat = $signed({1'b0, CAP47});
        end
        else if (oxy_neg < -$signed(50'(CAP47)) - 50'sd1)
        begin
            oxy_sat = $signed({1'b1, {QuoW{1'b0}}});
        end
        else
        begin
            oxy_sat = oxy_neg[47:0];
        end
        q_signed = $signed({1'b0, e_q_reg});

        result_next.reaction_valid = e_side_reg.ctl.rv;
        result_next.growth_valid   = e_side_reg.ctl.gv;
        result_next.last_out       = e_side_reg.ctl.last;
        if (e_side_reg.ctl.rv)
        begin
            result_next.nitrite_delta = -q_signed;
            result_next.nitrate_delta = q_signed;
            result_next.oxygen_delta  = oxy_sat;
        end
        else
        begin
            result_next.nitrite_delta = '0;
            result_next.nitrate_delta = '0;
            result_next.oxygen_delta  = '0;
        end
        if (e_side_reg.ctl.gv)
        begin
            result_next.net_growth = OutW'(e_side_reg.net);
        end
        else
        begin
            result_next.net_growth = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_IMPL(a_react_off_zero, result_valid && !result.reaction_valid,
        result.nitrite_delta == '0 && result.oxygen_delta == '0 && result.nitrate_delta == '0)
    `ASSERT_IMPL(a_growth_off_zero, result_valid && !result.growth_valid,
        result.net_growth == '0)
    `ASSERT_IMPL(a_nitrite_mirrors_nitrate, result_valid,
        result.nitrite_delta == -result.nitrate_delta)
    `ASSERT_NEVER(a_nitrate_negative, result_valid && result.nitrate_delta[47])

endmodule

`default_nettype wire
